[hdl/nggp_pkg.sv]
`default_nettype none
package nggp_pkg;

   // Field widths fixed by the coordinate format.
   localparam int WholeWidth    = 17;
   localparam int FracWidth     = 24;
   localparam int CoordWidth    = 35;
   localparam int MaxFracDigits = 7;
   localparam int DegScale      = 10000000;

   // Default digit limits of the coordinate text.
   localparam int DefWholeDigits    = 5;
   localparam int DefFractionDigits = 5;

   // Result channel packing.
   localparam int RspDataWidth = 72;
   localparam int RspUserWidth = 2;

   // Queue between the parser and the converter.
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Register levels in one conversion lane.
   localparam int ConvStages = 7;

   // Characters the parser reacts to.
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTilde = 8'h7E;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharPoint = 8'h2E;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharS     = 8'h53;
   localparam logic [7:0] CharW     = 8'h57;

   localparam logic [2:0] TagLength = 3'd6;
   localparam logic [2:0] CommaMax  = 3'd7;

   // Direction field: empty, exactly the negating letter, or anything else.
   typedef enum logic [1:0] {
      DirEmpty  = 2'd0,
      DirNegate = 2'd1,
      DirOther  = 2'd2
   } dir_type;

   // Running state of one coordinate field.
   typedef struct packed {
      logic [WholeWidth-1:0] whole;
      logic [FracWidth-1:0]  frac;
      logic                  digit;
      logic                  point;
      logic                  bad;
      logic [2:0]            cnt;
   } coord_acc_type;

   // One classified coordinate handed to the converter.
   typedef struct packed {
      logic [WholeWidth-1:0] whole;
      logic [FracWidth-1:0]  frac;
      logic                  bad;
      logic                  zero;
      logic                  neg;
   } coord_rec_type;

   typedef struct packed {
      coord_rec_type lon;
      coord_rec_type lat;
   } pos_rec_type;

   // Powers of ten used to place a fraction digit.
   function automatic logic [FracWidth-1:0] pow_ten(input logic [2:0] n);
      logic [FracWidth-1:0] r;
      unique case (n)
         3'd0:    r = 24'd1;
         3'd1:    r = 24'd10;
         3'd2:    r = 24'd100;
         3'd3:    r = 24'd1000;
         3'd4:    r = 24'd10000;
         3'd5:    r = 24'd100000;
         3'd6:    r = 24'd1000000;
         default: r = 24'd10000000;
      endcase
      return r;
   endfunction

   // Expected sentence tag, one character per position.
   function automatic logic [7:0] gga_tag(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0:    r = 8'h24;
         3'd1:    r = 8'h47;
         3'd2:    r = 8'h50;
         3'd3:    r = 8'h47;
         3'd4:    r = 8'h47;
         3'd5:    r = 8'h41;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/nggp_front.sv]
`default_nettype none
module nggp_front
   import nggp_pkg::*;
#(
   parameter int WHOLE_DIGITS    = DefWholeDigits,
   parameter int FRACTION_DIGITS = DefFractionDigits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte [7:0]
   input  wire logic        q_full,
   output logic             q_push,
   output pos_rec_type      q_data
);

   localparam logic [2:0] FieldLat    = 3'd2;
   localparam logic [2:0] FieldLatDir = 3'd3;
   localparam logic [2:0] FieldLon    = 3'd4;
   localparam logic [2:0] FieldLonDir = 3'd5;
   localparam logic [2:0] MinFields   = 3'd6;
   localparam logic [2:0] LastFields  = 3'd5;

   logic          prefix_fail_ff;
   logic [2:0]    prefix_len_ff, prefix_len_in;
   logic          prefix_fail_in;
   logic [2:0]    comma_cnt_ff, comma_cnt_in;
   logic          field_busy_ff, field_busy_in;
   coord_acc_type lat_ff, lat_in, lon_ff, lon_in;
   dir_type       lat_dir_ff, lat_dir_in, lon_dir_ff, lon_dir_in;
   logic          accept;
   logic [7:0]    c;

   // Folds one character into a coordinate field.
   function automatic coord_acc_type coord_char(input coord_acc_type a, input logic [7:0] ch);
      coord_acc_type r;
      logic [3:0]    d;
      logic [2:0]    n;
      r = a;
      d = ch[3:0];
      n = a.cnt + 3'd1;
      if (ch >= CharZero && ch <= CharNine) begin
         r.digit = 1'b1;
         if (!a.point) begin
            if (a.cnt >= 3'(WHOLE_DIGITS)) begin
               r.bad = 1'b1;
            end else begin
               r.whole = a.whole * 17'd10 + {13'd0, d};
               r.cnt   = n;
            end
         end else if (a.cnt < 3'(FRACTION_DIGITS)) begin
            r.cnt  = n;
            r.frac = a.frac + {20'd0, d} * pow_ten(3'(FRACTION_DIGITS) - n);
         end
      end else if (ch == CharPoint) begin
         if (a.point) begin
            r.bad = 1'b1;
         end else begin
            r.point = 1'b1;
            r.cnt   = 3'd0;
         end
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   // Decides at line end whether a coordinate is bad, zero or negated.
   function automatic coord_rec_type classify(input coord_acc_type a, input dir_type d);
      coord_rec_type r;
      r.whole = a.whole;
      r.frac  = a.frac;
      r.bad   = a.bad || (a.point && !a.digit);
      r.zero  = r.bad || !(a.digit || a.point);
      r.neg   = (d == DirNegate);
      return r;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;

   assign q_data.lat = classify(lat_ff, lat_dir_ff);
   assign q_data.lon = classify(lon_ff, lon_dir_ff);

   // Per-line parse state update.
   always_comb begin
      prefix_len_in  = prefix_len_ff;
      prefix_fail_in = prefix_fail_ff;
      comma_cnt_in   = comma_cnt_ff;
      field_busy_in  = field_busy_ff;
      lat_in         = lat_ff;
      lon_in         = lon_ff;
      lat_dir_in     = lat_dir_ff;
      lon_dir_in     = lon_dir_ff;
      q_push         = 1'b0;
      if (accept) begin
         if (c == CharLf) begin
            q_push = (prefix_len_ff == TagLength) && !prefix_fail_ff &&
                     ((comma_cnt_ff >= MinFields) ||
                      (comma_cnt_ff == LastFields && field_busy_ff));
            prefix_len_in  = 3'd0;
            prefix_fail_in = 1'b0;
            comma_cnt_in   = 3'd0;
            field_busy_in  = 1'b0;
            lat_in         = '0;
            lon_in         = '0;
            lat_dir_in     = DirEmpty;
            lon_dir_in     = DirEmpty;
         end else if (c >= CharSpace && c <= CharTilde) begin
            if (!prefix_fail_ff && prefix_len_ff < TagLength) begin
               if (c == gga_tag(prefix_len_ff)) begin
                  prefix_len_in = prefix_len_ff + 3'd1;
               end else begin
                  prefix_fail_in = 1'b1;
               end
            end
            if (c == CharComma) begin
               if (comma_cnt_ff != CommaMax) begin
                  comma_cnt_in = comma_cnt_ff + 3'd1;
               end
               field_busy_in = 1'b0;
            end else begin
               field_busy_in = 1'b1;
               unique case (comma_cnt_ff)
                  FieldLat:    lat_in = coord_char(lat_ff, c);
                  FieldLatDir: lat_dir_in = (lat_dir_ff == DirEmpty && c == CharS) ?
                                            DirNegate : DirOther;
                  FieldLon:    lon_in = coord_char(lon_ff, c);
                  FieldLonDir: lon_dir_in = (lon_dir_ff == DirEmpty && c == CharW) ?
                                            DirNegate : DirOther;
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_len_ff  <= 3'd0;
         prefix_fail_ff <= 1'b0;
         comma_cnt_ff   <= 3'd0;
         field_busy_ff  <= 1'b0;
         lat_ff         <= '0;
         lon_ff         <= '0;
         lat_dir_ff     <= DirEmpty;
         lon_dir_ff     <= DirEmpty;
      end else begin
         prefix_len_ff  <= prefix_len_in;
         prefix_fail_ff <= prefix_fail_in;
         comma_cnt_ff   <= comma_cnt_in;
         field_busy_ff  <= field_busy_in;
         lat_ff         <= lat_in;
         lon_ff         <= lon_in;
         lat_dir_ff     <= lat_dir_in;
         lon_dir_ff     <= lon_dir_in;
      end
   end

endmodule
`default_nettype wire

[hdl/nggp_fifo.sv]
`default_nettype none
module nggp_fifo
   import nggp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire pos_rec_type push_data,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output pos_rec_type      head
);

   pos_rec_type              entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign full  = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("record pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("record popped from an empty queue");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue occupancy did not follow a lone push");
`endif

endmodule
`default_nettype wire

[hdl/nggp_conv.sv]
`default_nettype none
module nggp_conv
   import nggp_pkg::*;
#(
   parameter int FRACTION_DIGITS = DefFractionDigits
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire coord_rec_type          rec,
   output logic signed [CoordWidth-1:0] value,
   output logic                        malformed
);

   // Fixed-point constants; the reciprocals undershoot by less than one unit.
   localparam int          Scale     = 10 ** FRACTION_DIGITS;
   localparam int          PostMul   = 10 ** (MaxFracDigits - FRACTION_DIGITS);
   localparam logic [17:0] Recip100  = 18'd167772;
   localparam logic [28:0] Recip15   = 29'd286331153;
   localparam logic [17:0] Hundred   = 18'd100;
   localparam logic [27:0] Fifteen   = 28'd15;

   typedef struct packed {
      logic bad;
      logic zero;
      logic neg;
   } meta_type;

   meta_type                meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff, meta6_ff;
   logic [WholeWidth-1:0]   whole1_ff;
   logic [FracWidth-1:0]    frac1_ff, frac2_ff;
   logic [34:0]             prod1_ff;
   logic [10:0]             qe100;
   logic [17:0]             rem100;
   logic [10:0]             deg2_ff, deg2_in;
   logic [6:0]              min2_ff, min2_in;
   logic [29:0]             x3_ff, y4;
   logic [CoordWidth-1:0]   degs3_ff, degs4_ff, degs5_ff, degs6_ff;
   logic [27:0]             z4_ff, z5_ff, r6;
   logic [56:0]             prod5_ff;
   logic [24:0]             qe15;
   logic [24:0]             q6_ff, q6_in;
   logic [CoordWidth-1:0]   mag;

   // Degrees and minutes of the whole part by reciprocal with one correction.
   always_comb begin
      qe100  = prod1_ff[34:24];
      rem100 = 18'(whole1_ff) - 18'(qe100) * Hundred;
      if (rem100 >= Hundred) begin
         deg2_in = qe100 + 11'd1;
         min2_in = 7'(rem100 - Hundred);
      end else begin
         deg2_in = qe100;
         min2_in = 7'(rem100);
      end
   end

   // Scale the minutes to 1e-7 units ahead of the divide by sixty.
   assign y4 = x3_ff * 30'(PostMul);

   // Quotient by fifteen with one correction step.
   always_comb begin
      qe15  = prod5_ff[56:32];
      r6    = z5_ff - 28'(qe15) * Fifteen;
      q6_in = (r6 >= Fifteen) ? qe15 + 25'd1 : qe15;
   end

   assign mag = degs6_ff + CoordWidth'(q6_ff);

   // Lane pipeline, frozen as a whole while the output stalls.
   always_ff @(posedge clock) begin
      if (en) begin
         whole1_ff <= rec.whole;
         frac1_ff  <= rec.frac;
         meta1_ff  <= '{bad: rec.bad, zero: rec.zero, neg: rec.neg};
         prod1_ff  <= 35'(rec.whole) * 35'(Recip100);

         deg2_ff   <= deg2_in;
         min2_ff   <= min2_in;
         frac2_ff  <= frac1_ff;
         meta2_ff  <= meta1_ff;

         x3_ff     <= 30'(min2_ff) * 30'(Scale) + 30'(frac2_ff);
         degs3_ff  <= CoordWidth'(deg2_ff) * CoordWidth'(DegScale);
         meta3_ff  <= meta2_ff;

         z4_ff     <= y4[29:2];
         degs4_ff  <= degs3_ff;
         meta4_ff  <= meta3_ff;

         prod5_ff  <= 57'(z4_ff) * 57'(Recip15);
         z5_ff     <= z4_ff;
         degs5_ff  <= degs4_ff;
         meta5_ff  <= meta4_ff;

         q6_ff     <= q6_in;
         degs6_ff  <= degs5_ff;
         meta6_ff  <= meta5_ff;

         malformed <= meta6_ff.bad;
         if (meta6_ff.zero) begin
            value <= '0;
         end else if (meta6_ff.neg) begin
            value <= -$signed(mag);
         end else begin
            value <= $signed(mag);
         end
      end
   end

endmodule
`default_nettype wire

[hdl/nggp_back.sv]
`default_nettype none
module nggp_back
   import nggp_pkg::*;
#(
   parameter int FRACTION_DIGITS = DefFractionDigits
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_empty,
   input  wire pos_rec_type             q_head,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata,
   output logic [RspUserWidth-1:0]      rsp_tuser
);

   logic [ConvStages-1:0]        valid_ff, valid_in;
   logic                         en;
   logic signed [CoordWidth-1:0] lat_value, lon_value;
   logic                         lat_bad, lon_bad;

   // The last lane register is the output register.
   assign rsp_tvalid = valid_ff[ConvStages-1];
   assign en         = !valid_ff[ConvStages-1] || rsp_tready;
   assign q_pop      = en && !q_empty;
   assign valid_in   = {valid_ff[ConvStages-2:0], !q_empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   nggp_conv #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lat_conv (
      .clock     (clock),
      .en        (en),
      .rec       (q_head.lat),
      .value     (lat_value),
      .malformed (lat_bad)
   );

   nggp_conv #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lon_conv (
      .clock     (clock),
      .en        (en),
      .rec       (q_head.lon),
      .value     (lon_value),
      .malformed (lon_bad)
   );

   assign rsp_tdata = {(RspDataWidth - 2 * CoordWidth)'(0), lon_value, lat_value};
   assign rsp_tuser = {lon_bad, lat_bad};

`ifndef SYNTH
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !q_pop)
      else $error("queue popped while the result is stalled");

   a_pop_enters_lane: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff[0])
      else $error("popped record did not enter the conversion lanes");

   a_stall_keeps_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while the output is stalled");
`endif

endmodule
`default_nettype wire

[hdl/nmea_gga_position_parser.sv]
`default_nettype none
// Takes one character per cycle on req_; req_tready drops only when the record queue is full.
// A position reaches rsp_ through the record queue and the seven register levels of the conversion
// lanes after the newline that ends its line; results stream one per cycle while rsp_tready is high.
// The four-entry record queue lets the parser run on while the result side is stalled.
// Reset is synchronous and active high; it clears the line state, the queue and the lane
// valid bits. No clearing pass follows reset.
module nmea_gga_position_parser
   import nggp_pkg::*;
#(
   parameter int WHOLE_DIGITS    = DefWholeDigits,
   parameter int FRACTION_DIGITS = DefFractionDigits
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,   // rx_byte [7:0]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata,   // latitude [34:0], longitude [69:35], zero pad
   output logic [RspUserWidth-1:0]      rsp_tuser    // latitude_malformed [0], longitude_malformed [1]
);

   logic        q_push, q_full, q_pop, q_empty;
   pos_rec_type q_data, q_head;

   nggp_front #(
      .WHOLE_DIGITS    (WHOLE_DIGITS),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   nggp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   nggp_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[tb/sv/tb_nmea_gga_position_parser.sv]
module tb_nmea_gga_position_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import nggp_pkg::*;

   localparam int    WholeDigits    = DefWholeDigits;
   localparam int    FractionDigits = DefFractionDigits;
   localparam int    StallMax       = 16;
   localparam int    IdleLimit      = 2000;
   localparam int    TailCycles     = 40;
   localparam int    ItemGoal       = 1450;
   localparam string SentenceTag    = "$GPGGA";

   // Comma fields that carry the position.
   localparam int LatField    = 2;
   localparam int LatDirField = 3;
   localparam int LonField    = 4;
   localparam int LonDirField = 5;

   localparam logic [7:0] CharN = "N";
   localparam logic [7:0] CharE = "E";

   // Running text of one coordinate field.
   typedef struct packed {
      logic [WholeWidth-1:0] whole;
      logic [WholeWidth-1:0] frac;
      logic                  digit;
      logic                  point;
      logic                  bad;
      logic [2:0]            cnt;
   } coord_text_type;

   // One position as it should appear on the result channel.
   typedef struct packed {
      logic [CoordWidth-1:0] lat;
      logic [CoordWidth-1:0] lon;
      logic                  lat_bad;
      logic                  lon_bad;
   } position_type;

   // Tracks the line being received and holds the positions still owed by the block.
   class gga_tracker_type;
      logic [2:0]     tag_seen;
      logic           tag_wrong;
      logic [2:0]     commas;
      logic           field_open;
      coord_text_type lat_text;
      coord_text_type lon_text;
      dir_type        lat_dir;
      dir_type        lon_dir;
      position_type   positions_due[$];
      int             chars_taken;
      int             faults;

      function new();
         clear_line();
         chars_taken = 0;
         faults      = 0;
      endfunction

      function void clear_line();
         tag_seen   = '0;
         tag_wrong  = 1'b0;
         commas     = '0;
         field_open = 1'b0;
         lat_text   = '0;
         lon_text   = '0;
         lat_dir    = DirEmpty;
         lon_dir    = DirEmpty;
      endfunction

      static function longint unsigned ten_to(int n);
         longint unsigned r;
         r = 1;
         repeat (n) r = r * 10;
         return r;
      endfunction

      // Adds one character to the text of a coordinate field.
      static function coord_text_type coord_step(coord_text_type t, logic [7:0] c);
         logic [3:0] d;
         if (c >= CharZero && c <= CharNine) begin
            d = 4'(c - CharZero);
            t.digit = 1'b1;
            if (!t.point) begin
               if (t.cnt >= WholeDigits) begin
                  t.bad = 1'b1;
               end else begin
                  t.whole = WholeWidth'(t.whole * 10 + d);
                  t.cnt   = t.cnt + 3'd1;
               end
            end else if (t.cnt < FractionDigits) begin
               t.cnt  = t.cnt + 3'd1;
               t.frac = WholeWidth'(t.frac + d * ten_to(FractionDigits - t.cnt));
            end
         end else if (c == CharPoint) begin
            if (t.point) begin
               t.bad = 1'b1;
            end else begin
               t.point = 1'b1;
               t.cnt   = '0;
            end
         end else begin
            t.bad = 1'b1;
         end
         return t;
      endfunction

      static function dir_type dir_step(dir_type d, logic [7:0] c, logic [7:0] letter);
         return (d == DirEmpty && c == letter) ? DirNegate : DirOther;
      endfunction

      // Converts ddmm.mmmm text to signed units of 1e-7 degree, truncating.
      static function logic [CoordWidth-1:0] coord_value(coord_text_type t, dir_type d,
                                                         output logic bad);
         longint unsigned w, scale, num, mag;
         bad = t.bad || (t.point && !t.digit);
         if (bad || !(t.digit || t.point)) return '0;
         w     = t.whole;
         scale = ten_to(FractionDigits);
         num   = ((w % 100) * scale + t.frac) * DegScale;
         mag   = (w / 100) * DegScale + num / (60 * scale);
         if (d == DirNegate) mag = -mag;
         return mag[CoordWidth-1:0];
      endfunction

      // Called for every accepted request transaction.
      function void take_char(logic [7:0] c);
         position_type p;
         logic         lat_bad, lon_bad;
         if (c == CharLf) begin
            chars_taken++;
            if (tag_seen == TagLength && !tag_wrong &&
                (commas > LonDirField || (commas == LonDirField && field_open))) begin
               p.lat     = coord_value(lat_text, lat_dir, lat_bad);
               p.lon     = coord_value(lon_text, lon_dir, lon_bad);
               p.lat_bad = lat_bad;
               p.lon_bad = lon_bad;
               positions_due.insert(positions_due.size(), p);
            end
            clear_line();
            return;
         end
         // Control and high bytes are dropped by the block.
         if (c < CharSpace || c > CharTilde) return;
         chars_taken++;
         if (!tag_wrong && tag_seen < TagLength) begin
            if (c == SentenceTag[tag_seen]) tag_seen = tag_seen + 3'd1;
            else tag_wrong = 1'b1;
         end
         if (c == CharComma) begin
            if (commas < CommaMax) commas = commas + 3'd1;
            field_open = 1'b0;
            return;
         end
         field_open = 1'b1;
         case (int'(commas))
            LatField:    lat_text = coord_step(lat_text, c);
            LatDirField: lat_dir  = dir_step(lat_dir, c, CharS);
            LonField:    lon_text = coord_step(lon_text, c);
            LonDirField: lon_dir  = dir_step(lon_dir, c, CharW);
            default: ;
         endcase
      endfunction

      function void fault(string msg);
         faults++;
         if (faults <= 10) $display("%s", msg);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) fault($sformatf("mismatch in %s: expected %0d, got %0d",
                                          name, want, got));
      endfunction

      // Called for every accepted response transaction.
      function void match_position(logic [RspDataWidth-1:0] data,
                                   logic [RspUserWidth-1:0] user);
         position_type p;
         if (positions_due.size() == 0) begin
            fault($sformatf("position with none pending: data %h, user %b", data, user));
            return;
         end
         p = positions_due.pop_front();
         compare_field("latitude", longint'($signed(p.lat)),
                       longint'($signed(data[CoordWidth-1:0])));
         compare_field("longitude", longint'($signed(p.lon)),
                       longint'($signed(data[2*CoordWidth-1:CoordWidth])));
         compare_field("latitude_malformed", longint'(p.lat_bad), longint'(user[0]));
         compare_field("longitude_malformed", longint'(p.lon_bad), longint'(user[1]));
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [RspUserWidth-1:0] rsp_tuser;

   logic            tx_steady = 1'b0;
   logic            rx_steady = 1'b0;
   logic [7:0]      line_bytes[$];
   gga_tracker_type tracker;

   nmea_gga_position_parser #(
      .WHOLE_DIGITS    (WholeDigits),
      .FRACTION_DIGITS (FractionDigits)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Sentence text builders.
   function automatic void put_byte(logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void put_digits(int n);
      repeat (n) put_byte(8'(CharZero + $urandom_range(0, 9)));
   endfunction

   // A printable character that is neither a digit, a point nor a comma.
   function automatic logic [7:0] text_noise();
      logic [7:0] c;
      do c = 8'($urandom_range(CharSpace, CharTilde));
      while ((c >= CharZero && c <= CharNine) || c == CharPoint || c == CharComma);
      return c;
   endfunction

   // A byte that the block discards.
   function automatic logic [7:0] dropped_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CharLf || (c >= CharSpace && c <= CharTilde));
      return c;
   endfunction

   function automatic void put_coord();
      int wd;
      case ($urandom_range(0, 15))
         0: ;
         11: begin
            put_digits($urandom_range(WholeDigits + 1, 7));
            put_text(".");
            put_digits($urandom_range(0, 3));
         end
         12: begin
            put_digits($urandom_range(0, 5));
            put_byte(text_noise());
            put_text(".");
            put_digits($urandom_range(0, 5));
         end
         13: begin
            put_digits(2);
            put_text(".");
            put_digits(1);
            put_text(".");
            put_digits(2);
         end
         14: put_text(".");
         15: repeat ($urandom_range(1, 4)) put_byte(text_noise());
         default: begin
            wd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WholeDigits)
                                             : $urandom_range(WholeDigits - 1, WholeDigits);
            put_digits(wd);
            if ($urandom_range(0, 9) != 0) begin
               put_text(".");
               put_digits($urandom_range(0, 7));
            end
         end
      endcase
   endfunction

   function automatic void put_dir(logic [7:0] neg, logic [7:0] other);
      case ($urandom_range(0, 11))
         0: ;
         1, 2, 3, 4, 5: put_byte(neg);
         6, 7, 8: put_byte(other);
         9: begin
            put_byte(neg);
            put_byte(neg);
         end
         10: put_byte(text_noise());
         default: begin
            put_byte(neg);
            put_byte(text_noise());
         end
      endcase
   endfunction

   // Mostly well-formed sentences with random fields; the rest are broken lines and noise.
   function automatic void build_random_line();
      int         kind, pos;
      logic [7:0] c;
      kind = $urandom_range(0, 19);
      if (kind == 17) begin
         // Empty line.
      end else if (kind == 18) begin
         repeat ($urandom_range(1, 30)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CharLf);
            put_byte(c);
         end
      end else begin
         if (kind == 14) begin
            pos = $urandom_range(0, 5);
            for (int i = 0; i < 6; i++) begin
               if (i == pos) begin
                  do c = 8'($urandom_range(CharSpace, CharTilde)); while (c == SentenceTag[i]);
                  put_byte(c);
               end else begin
                  put_byte(SentenceTag[i]);
               end
            end
         end else if (kind == 15) begin
            put_text(SentenceTag.substr(0, $urandom_range(0, 4)));
         end else begin
            put_text(SentenceTag);
         end
         if (kind == 16) begin
            repeat ($urandom_range(0, 4)) begin
               put_text(",");
               put_digits($urandom_range(0, 4));
            end
         end else begin
            put_text(",");
            put_digits($urandom_range(0, 6));
            put_text(",");
            put_coord();
            put_text(",");
            put_dir(CharS, CharN);
            put_text(",");
            put_coord();
            put_text(",");
            put_dir(CharW, CharE);
            case ($urandom_range(0, 3))
               0: ;
               1: put_text(",");
               default: begin
                  repeat ($urandom_range(1, 6)) begin
                     put_text(",");
                     put_digits($urandom_range(0, 3));
                  end
               end
            endcase
         end
      end
      put_byte(CharLf);
   endfunction

   // Offers one character and waits for its transaction.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, StallMax);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      tracker.take_char(c);
   endtask

   task automatic send_line(input logic with_junk);
      foreach (line_bytes[i]) begin
         if (with_junk && $urandom_range(0, 24) == 0) send_char(dropped_byte());
         send_char(line_bytes[i]);
      end
      line_bytes.delete();
      if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
   endtask

   task automatic send_text(input string s);
      put_text(s);
      send_line(1'b0);
   endtask

   // Holds the request side idle until every pending position has come out.
   task automatic drain_positions();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.positions_due.size() != 0) @(posedge clock);
   endtask

   // Stimulus and end of run.
   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Largest values, both negated.
      send_text("$GPGGA,1,99999.99999,S,99999.99999,W\n");
      // Zero values with other directions, and a trailing empty field.
      send_text("$GPGGA,,00000.00000,N,00000.00000,E,\n");
      // Empty coordinates.
      send_text("$GPGGA,,,,,,\n");
      // Bad text: a letter in the digits, two points.
      send_text("$GPGGA,,48A7.5,N,1.2.3,E,1\n");
      // Bad text: no digit at all, too many whole digits.
      send_text("$GPGGA,,.,S,123456.1,W,1\n");
      // Extra fraction digits, doubled direction, fields past the longitude.
      send_text("$GPGGA,,4807.0381234,SS,.5,w,1,2,3,4,5\n");
      // Too few fields.
      send_text("$GPGGA,,4807,S,01131\n");
      // Five commas but the last field is empty.
      send_text("$GPGGA,,1,S,2,\n");
      // Wrong tag, short tag and an empty line.
      send_text("$GPGGB,,1,S,2,W,\n");
      send_text("$GPG\n");
      send_text("\n");
      // Dropped bytes inside a sentence.
      put_text("$GP");
      put_byte(8'hFF);
      put_byte(8'h00);
      put_byte(8'h80);
      put_text("GGA,,12.5,S,3,W");
      put_byte(8'h7F);
      put_byte(8'h1F);
      put_byte(CharLf);
      send_line(1'b0);
      drain_positions();

      while (tracker.chars_taken < ItemGoal) begin
         build_random_line();
         send_line(1'b1);
         if ($urandom_range(0, 19) == 0) drain_positions();
      end

      drain_positions();
      repeat (TailCycles) @(posedge clock);
      if (tracker.faults == 0 && tracker.positions_due.size() == 0) begin
         $display("tb_nmea_gga_position_parser: done, clean");
      end else begin
         $display("tb_nmea_gga_position_parser: done, errors");
      end
      $finish;
   end

   // Response side: random stalls, with stretches of none.
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = rx_steady ? 0 : $urandom_range(0, StallMax);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.match_position(rsp_tdata, rsp_tuser);
         if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      end
   end

   // Watchdog: ends the run when no transaction happens for too long.
   initial begin
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("tb_nmea_gga_position_parser: done, errors");
      $finish;
   end

endmodule
